// File: rtl/best_fit_coalescing_allocator_macros.svh
// Assertion macros for the best-fit allocator checkers.
// Needs a clock and an active-low reset in the scope that uses them.
`ifndef BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH
`define BEST_FIT_COALESCING_ALLOCATOR_MACROS_SVH

// Assert a property on an explicit clock, off while reset is low.
`define BFCA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assert a property on clk_i and rst_ni.
`define BFCA_ASSERT(lbl, prop, msg) \
  `BFCA_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/bfca_pkg.sv
// Shared widths, codes and default parameters of the best-fit allocator.
// No dependencies.
package bfca_pkg;

  localparam int AddrW    = 16;
  localparam int SizeW    = 17;
  localparam int CalcW    = 18;
  localparam int FreeOutW = 5;
  localparam int LiveW    = 16;

  localparam int MinPool  = 8192;
  localparam int SplitCap = 128;
  localparam logic [SizeW-1:0] PoolReset = 17'd65536;

  localparam int DefMaxPoolBytes = 65536;
  localparam int DefFreeSlots    = 16;
  localparam int DefWordBytes    = 8;
  localparam int DefHeaderBytes  = 24;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  typedef enum logic [1:0] {
    StOk   = 2'd0,
    StOom  = 2'd1,
    StDup  = 2'd2,
    StFull = 2'd3
  } status_e;

endpackage

// File: rtl/bfca_req_if.sv
// Request channel of the allocator: valid/ready plus one alloc or free item.
// Depends on bfca_pkg.
interface bfca_req_if;
  import bfca_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [AddrW-1:0]  req_bytes;
  logic [AddrW-1:0]  blk_addr;
  logic [SizeW-1:0]  blk_bytes;

  modport source (output valid, op, req_bytes, blk_addr, blk_bytes, input ready);
  modport sink   (input valid, op, req_bytes, blk_addr, blk_bytes, output ready);
endinterface

// File: rtl/bfca_rsp_if.sv
// Response channel of the allocator: valid/ready plus one result item.
// Depends on bfca_pkg.
interface bfca_rsp_if;
  import bfca_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [AddrW-1:0]    grant_addr;
  logic [SizeW-1:0]    grant_bytes;
  logic [FreeOutW-1:0] free_extents;
  logic [LiveW-1:0]    live_count;

  modport source (output valid, status, grant_addr, grant_bytes, free_extents, live_count,
                  input ready);
  modport sink   (input valid, status, grant_addr, grant_bytes, free_extents, live_count,
                  output ready);
endinterface

// File: rtl/bfca_size_round.sv
// Rounds header plus request up to whole words and forms the split limit.
// Two register stages; depends on bfca_pkg.
module bfca_size_round #(
  parameter int WordBytes   = bfca_pkg::DefWordBytes,
  parameter int HeaderBytes = bfca_pkg::DefHeaderBytes
) (
  input  logic                      clk_i,
  input  logic [bfca_pkg::AddrW-1:0] req_bytes_i,
  output logic [bfca_pkg::CalcW-1:0] size_o,
  output logic [bfca_pkg::CalcW:0]   limit_o
);
  import bfca_pkg::*;

  localparam int RecipSh = 26;
  localparam logic [RecipSh:0] Recip = (RecipSh+1)'(((2**RecipSh) + WordBytes - 1) / WordBytes);

  logic [CalcW-1:0]         sum;
  logic [CalcW+RecipSh:0]   prod;
  logic [CalcW-1:0]         quot_q;
  logic [2*CalcW-1:0]       mult;
  logic [CalcW-1:0]         size_q;
  logic [CalcW:0]           twice;
  logic [CalcW:0]           margin;

  assign sum  = CalcW'(req_bytes_i) + CalcW'(HeaderBytes) + CalcW'(WordBytes - 1);
  // divide by the word size through a reciprocal; exact for these widths
  assign prod = (CalcW+RecipSh+1)'(sum) * (CalcW+RecipSh+1)'(Recip);
  assign mult = (2*CalcW)'(quot_q) * (2*CalcW)'(WordBytes);

  always_ff @(posedge clk_i) begin
    quot_q <= prod[CalcW+RecipSh-1:RecipSh];
    size_q <= mult[CalcW-1:0];
  end

  assign twice   = {size_q, 1'b0};
  assign margin  = (twice < (CalcW+1)'(SplitCap)) ? twice : (CalcW+1)'(SplitCap);
  assign size_o  = size_q;
  assign limit_o = (CalcW+1)'(size_q) + margin;
endmodule

// File: rtl/best_fit_coalescing_allocator.sv
// Best-fit allocator with coalescing for one pool. Each item has its size
// rounded, then scans the free extents, then moves table entries one at a
// time when the table is compacted or opened. The extent table is one
// synchronous memory read once and written once per cycle. One item is
// worked on at a time.
// Depends on bfca_pkg, bfca_req_if, bfca_rsp_if and bfca_size_round.
module best_fit_coalescing_allocator #(
  parameter int MaxPoolBytes = bfca_pkg::DefMaxPoolBytes,
  parameter int FreeSlots    = bfca_pkg::DefFreeSlots,
  parameter int WordBytes    = bfca_pkg::DefWordBytes,
  parameter int HeaderBytes  = bfca_pkg::DefHeaderBytes
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bfca_pkg::SizeW-1:0] cfg_wdata_i,
  bfca_req_if.sink                   req_i,
  bfca_rsp_if.source                 rsp_o
);
  import bfca_pkg::*;

  localparam int IW = $clog2(FreeSlots);
  localparam int CW = $clog2(FreeSlots + 1);
  localparam int EW = AddrW + SizeW;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SRnd0   = 4'd1;
  localparam logic [3:0] SRnd1   = 4'd2;
  localparam logic [3:0] SStart  = 4'd3;
  localparam logic [3:0] SAScan  = 4'd4;
  localparam logic [3:0] SAGrant = 4'd5;
  localparam logic [3:0] SBump   = 4'd6;
  localparam logic [3:0] SFScan  = 4'd7;
  localparam logic [3:0] SFDec   = 4'd8;
  localparam logic [3:0] SShDn   = 4'd9;
  localparam logic [3:0] SShUp   = 4'd10;
  localparam logic [3:0] SIns    = 4'd11;
  localparam logic [3:0] SDone   = 4'd12;

  logic [3:0] state_q, state_d;

  logic             op_q, op_d;
  logic [AddrW-1:0] req_q, req_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [SizeW-1:0] bytes_q, bytes_d;

  logic [SizeW-1:0] pool_q;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [SizeW-1:0] bump_q, bump_d;
  logic [LiveW-1:0] live_q, live_d;

  logic [IW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             found_q, found_d;
  logic [IW-1:0]    best_q, best_d;
  logic [AddrW-1:0] best_start_q, best_start_d;
  logic [SizeW-1:0] best_size_q, best_size_d;
  logic             has_prev_q, has_prev_d;
  logic [AddrW-1:0] prev_start_q, prev_start_d;
  logic [SizeW-1:0] prev_size_q, prev_size_d;
  logic             has_next_q, has_next_d;
  logic [AddrW-1:0] next_start_q, next_start_d;
  logic [SizeW-1:0] next_size_q, next_size_d;

  status_e          res_status_q, res_status_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic [SizeW-1:0] res_bytes_q, res_bytes_d;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [AddrW-1:0]    out_addr_q, out_addr_d;
  logic [SizeW-1:0]    out_bytes_q, out_bytes_d;
  logic [FreeOutW-1:0] out_free_q, out_free_d;
  logic [LiveW-1:0]    out_live_q, out_live_d;

  // extent table: {start, size} per entry
  logic [EW-1:0]    mem_q [FreeSlots];
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic [EW-1:0]    rdata_q;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;
  logic [AddrW-1:0] rd_start;
  logic [SizeW-1:0] rd_size;

  logic [CalcW-1:0] size;
  logic [CalcW:0]   limit;
  logic [SizeW-1:0] pool_lim;
  logic [CW-1:0]    idx_nxt;
  logic [CalcW-1:0] blk_end;
  logic [CalcW-1:0] prev_end;
  logic             fit_hit;
  logic             dup_hit;
  logic             join_prev;
  logic             join_next;
  logic [LiveW-1:0] live_inc;

  bfca_size_round #(
    .WordBytes  (WordBytes),
    .HeaderBytes(HeaderBytes)
  ) u_size_round (
    .clk_i      (clk_i),
    .req_bytes_i(req_q),
    .size_o     (size),
    .limit_o    (limit)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign rd_start = rdata_q[EW-1:SizeW];
  assign rd_size  = rdata_q[SizeW-1:0];

  always_comb begin
    if (pool_q < SizeW'(MinPool)) begin
      pool_lim = SizeW'(MinPool);
    end else if (32'(pool_q) > 32'(MaxPoolBytes)) begin
      pool_lim = SizeW'(MaxPoolBytes);
    end else begin
      pool_lim = pool_q;
    end
  end

  assign idx_nxt   = CW'(idx_q) + CW'(1);
  assign blk_end   = CalcW'(addr_q) + CalcW'(bytes_q);
  assign prev_end  = CalcW'(prev_start_q) + CalcW'(prev_size_q);
  assign fit_hit   = (CalcW'(rd_size) >= size) && (!found_q || rd_size < best_size_q);
  assign dup_hit   = (has_next_q && (next_start_q == addr_q ||
                                     blk_end > CalcW'(next_start_q))) ||
                     (has_prev_q && prev_end > CalcW'(addr_q));
  assign join_prev = has_prev_q && prev_end == CalcW'(addr_q);
  assign join_next = has_next_q && blk_end == CalcW'(next_start_q);
  assign live_inc  = (live_q == {LiveW{1'b1}}) ? live_q : live_q + LiveW'(1);

  assign req_i.ready        = (state_q == SIdle);
  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.grant_addr   = out_addr_q;
  assign rsp_o.grant_bytes  = out_bytes_q;
  assign rsp_o.free_extents = out_free_q;
  assign rsp_o.live_count   = out_live_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    req_d        = req_q;
    addr_d       = addr_q;
    bytes_d      = bytes_q;
    cnt_d        = cnt_q;
    bump_d       = bump_q;
    live_d       = live_q;
    idx_d        = idx_q;
    pos_d        = pos_q;
    found_d      = found_q;
    best_d       = best_q;
    best_start_d = best_start_q;
    best_size_d  = best_size_q;
    has_prev_d   = has_prev_q;
    prev_start_d = prev_start_q;
    prev_size_d  = prev_size_q;
    has_next_d   = has_next_q;
    next_start_d = next_start_q;
    next_size_d  = next_size_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_bytes_d  = res_bytes_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_bytes_d  = out_bytes_q;
    out_free_d   = out_free_q;
    out_live_d   = out_live_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = '0;

    case (state_q)
      SIdle: begin
        if (req_i.valid) begin
          op_d         = req_i.op;
          req_d        = req_i.req_bytes;
          addr_d       = req_i.blk_addr;
          bytes_d      = req_i.blk_bytes;
          found_d      = 1'b0;
          has_prev_d   = 1'b0;
          has_next_d   = 1'b0;
          res_status_d = StOk;
          res_addr_d   = '0;
          res_bytes_d  = '0;
          state_d      = SRnd0;
        end
      end
      SRnd0: state_d = SRnd1;
      SRnd1: state_d = SStart;
      SStart: begin
        idx_d = '0;
        if (op_q == OpAlloc) begin
          if (size != '0 && cnt_q != '0) begin
            rd_en   = 1'b1;
            state_d = SAScan;
          end else begin
            state_d = SBump;
          end
        end else if (live_q == '0) begin
          res_status_d = StDup;
          state_d      = SDone;
        end else if (cnt_q == '0) begin
          pos_d   = '0;
          state_d = SFDec;
        end else begin
          rd_en   = 1'b1;
          state_d = SFScan;
        end
      end
      SAScan: begin
        if (fit_hit) begin
          found_d      = 1'b1;
          best_d       = idx_q;
          best_start_d = rd_start;
          best_size_d  = rd_size;
        end
        // stop early on an exact fit
        if ((fit_hit && CalcW'(rd_size) == size) || idx_nxt >= cnt_q) begin
          state_d = SAGrant;
        end else begin
          idx_d   = idx_q + IW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q + IW'(1);
        end
      end
      SAGrant: begin
        if (!found_q) begin
          state_d = SBump;
        end else begin
          res_addr_d = best_start_q;
          live_d     = live_inc;
          if ((CalcW+1)'(best_size_q) >= limit) begin
            wr_en       = 1'b1;
            wr_addr     = best_q;
            wr_data     = {AddrW'(best_start_q + size[AddrW-1:0]),
                           SizeW'(best_size_q - size[SizeW-1:0])};
            res_bytes_d = size[SizeW-1:0];
            state_d     = SDone;
          end else begin
            res_bytes_d = best_size_q;
            if (CW'(best_q) + CW'(1) < cnt_q) begin
              rd_en   = 1'b1;
              rd_addr = best_q + IW'(1);
              idx_d   = best_q + IW'(1);
              state_d = SShDn;
            end else begin
              cnt_d   = cnt_q - CW'(1);
              state_d = SDone;
            end
          end
        end
      end
      SBump: begin
        if (bump_q > pool_lim || CalcW'(pool_lim - bump_q) < size) begin
          res_status_d = StOom;
        end else begin
          res_addr_d  = bump_q[AddrW-1:0];
          res_bytes_d = size[SizeW-1:0];
          bump_d      = SizeW'(CalcW'(bump_q) + size);
          live_d      = live_inc;
        end
        state_d = SDone;
      end
      SFScan: begin
        if (rd_start < addr_q) begin
          has_prev_d   = 1'b1;
          prev_start_d = rd_start;
          prev_size_d  = rd_size;
          if (idx_nxt < cnt_q) begin
            idx_d   = idx_q + IW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_q + IW'(1);
          end else begin
            pos_d   = cnt_q;
            state_d = SFDec;
          end
        end else begin
          pos_d        = CW'(idx_q);
          has_next_d   = 1'b1;
          next_start_d = rd_start;
          next_size_d  = rd_size;
          state_d      = SFDec;
        end
      end
      SFDec: begin
        state_d = SDone;
        if (dup_hit) begin
          res_status_d = StDup;
        end else if (!join_prev && !join_next && cnt_q >= CW'(FreeSlots)) begin
          res_status_d = StFull;
        end else if (live_q == LiveW'(1)) begin
          // last live block: the pool returns to empty
          live_d = '0;
          cnt_d  = '0;
          bump_d = '0;
        end else begin
          live_d = live_q - LiveW'(1);
          if (join_prev && join_next) begin
            wr_en   = 1'b1;
            wr_addr = IW'(pos_q - CW'(1));
            wr_data = {prev_start_q, SizeW'(prev_size_q + bytes_q + next_size_q)};
            if (pos_q + CW'(1) < cnt_q) begin
              rd_en   = 1'b1;
              rd_addr = IW'(pos_q + CW'(1));
              idx_d   = IW'(pos_q + CW'(1));
              state_d = SShDn;
            end else begin
              cnt_d = cnt_q - CW'(1);
            end
          end else if (join_prev) begin
            wr_en   = 1'b1;
            wr_addr = IW'(pos_q - CW'(1));
            wr_data = {prev_start_q, SizeW'(prev_size_q + bytes_q)};
          end else if (join_next) begin
            wr_en   = 1'b1;
            wr_addr = IW'(pos_q);
            wr_data = {addr_q, SizeW'(next_size_q + bytes_q)};
          end else if (pos_q < cnt_q) begin
            // open a slot: move entries up from the top
            rd_en   = 1'b1;
            rd_addr = IW'(cnt_q - CW'(1));
            idx_d   = IW'(cnt_q - CW'(1));
            state_d = SShUp;
          end else begin
            state_d = SIns;
          end
        end
      end
      SShDn: begin
        wr_en   = 1'b1;
        wr_addr = idx_q - IW'(1);
        wr_data = rdata_q;
        if (idx_nxt < cnt_q) begin
          idx_d   = idx_q + IW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q + IW'(1);
        end else begin
          cnt_d   = cnt_q - CW'(1);
          state_d = SDone;
        end
      end
      SShUp: begin
        wr_en   = 1'b1;
        wr_addr = idx_q + IW'(1);
        wr_data = rdata_q;
        if (CW'(idx_q) > pos_q) begin
          idx_d   = idx_q - IW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q - IW'(1);
        end else begin
          state_d = SIns;
        end
      end
      SIns: begin
        wr_en   = 1'b1;
        wr_addr = IW'(pos_q);
        wr_data = {addr_q, bytes_q};
        cnt_d   = cnt_q + CW'(1);
        state_d = SDone;
      end
      SDone: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          out_bytes_d  = res_bytes_q;
          out_free_d   = FreeOutW'(cnt_q);
          out_live_d   = live_q;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pool_q      <= PoolReset;
      cnt_q       <= '0;
      bump_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      bump_q      <= bump_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        pool_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    req_q        <= req_d;
    addr_q       <= addr_d;
    bytes_q      <= bytes_d;
    idx_q        <= idx_d;
    pos_q        <= pos_d;
    found_q      <= found_d;
    best_q       <= best_d;
    best_start_q <= best_start_d;
    best_size_q  <= best_size_d;
    has_prev_q   <= has_prev_d;
    prev_start_q <= prev_start_d;
    prev_size_q  <= prev_size_d;
    has_next_q   <= has_next_d;
    next_start_q <= next_start_d;
    next_size_q  <= next_size_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_bytes_q  <= res_bytes_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_bytes_q  <= out_bytes_d;
    out_free_q   <= out_free_d;
    out_live_q   <= out_live_d;
  end
endmodule

// File: rtl/bfca_checker.sv
// Port-level checks of the best-fit allocator, bound to the top level.
// Depends on bfca_pkg and best_fit_coalescing_allocator_macros.svh.
`include "best_fit_coalescing_allocator_macros.svh"

module bfca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [1:0]                    status_i,
  input logic [bfca_pkg::AddrW-1:0]    grant_addr_i,
  input logic [bfca_pkg::SizeW-1:0]    grant_bytes_i,
  input logic [bfca_pkg::FreeOutW-1:0] free_extents_i,
  input logic [bfca_pkg::LiveW-1:0]    live_count_i
);
  import bfca_pkg::*;

  `BFCA_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped")
  `BFCA_ASSERT(a_fail_zero, out_valid_i && status_i != StOk |-> grant_addr_i == '0 && grant_bytes_i == '0, "failed item carries a grant")
  `BFCA_ASSERT(a_empty_pool, out_valid_i && live_count_i == '0 |-> free_extents_i == '0, "free extents left with nothing live")
  `BFCA_ASSERT(a_busy, in_valid_i && in_ready_i |=> !in_ready_i, "item taken while busy")
endmodule

bind best_fit_coalescing_allocator bfca_checker u_bfca_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .grant_addr_i  (rsp_o.grant_addr),
  .grant_bytes_i (rsp_o.grant_bytes),
  .free_extents_i(rsp_o.free_extents),
  .live_count_i  (rsp_o.live_count)
);

// File: tb/sv/tb_best_fit_coalescing_allocator.sv
// Testbench for the best-fit coalescing allocator: directed rows, full table, random alloc/free.
// Predicts every result with a local allocator model; depends on bfca_pkg, bfca_req_if, bfca_rsp_if.
module tb_best_fit_coalescing_allocator;
  import bfca_pkg::*;

  localparam int Slots   = DefFreeSlots;
  localparam int WordB   = DefWordBytes;
  localparam int HeadB   = DefHeaderBytes;
  localparam int MaxPool = DefMaxPoolBytes;
  localparam int Limit   = 20000;

  typedef struct packed {
    logic             op;
    logic [AddrW-1:0] req;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] bytes;
  } alloc_item_t;

  typedef struct packed {
    status_e             status;
    logic [AddrW-1:0]    gaddr;
    logic [SizeW-1:0]    gbytes;
    logic [FreeOutW-1:0] nfree;
    logic [LiveW-1:0]    live;
  } grant_t;

  // directed row: chk set means the typed result is compared with the predictor's
  typedef struct {
    alloc_item_t item;
    bit          chk;
    grant_t      res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [SizeW-1:0] cfg_wdata_i = '0;

  bfca_req_if req_if ();
  bfca_rsp_if rsp_if ();

  best_fit_coalescing_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  always #2 clk_i = ~clk_i;

  // predictor state
  int unsigned pool_reg;
  int unsigned ext_start[Slots];
  int unsigned ext_size[Slots];
  int unsigned ext_cnt, bump, live_n;

  grant_t      grant_q[$];
  alloc_item_t live_q[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          hold_rsp = 1'b0;
  bit          timed_out = 1'b0;

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  function automatic void drop_extent(int unsigned k);
    for (int unsigned j = k; j + 1 < ext_cnt; j++) begin
      ext_start[j] = ext_start[j+1];
      ext_size[j]  = ext_size[j+1];
    end
    ext_cnt--;
  endfunction

  function automatic grant_t predict_grant(alloc_item_t it);
    grant_t r;
    int unsigned sz, pool, best, best_sz, margin, pos, fin;
    bit found, jp, jn, hp, hn;
    r = '0;
    r.status = StOk;
    pool = pool_reg < MinPool ? MinPool : (pool_reg > MaxPool ? MaxPool : pool_reg);
    if (it.op == OpAlloc) begin
      sz = ((HeadB + it.req + WordB - 1) / WordB) * WordB;
      found = 0;
      best = 0;
      best_sz = 0;
      if (sz != 0) begin
        for (int unsigned i = 0; i < ext_cnt; i++) begin
          if (ext_size[i] >= sz && (!found || ext_size[i] < best_sz)) begin
            found = 1;
            best = i;
            best_sz = ext_size[i];
            if (best_sz == sz) break;
          end
        end
      end
      if (found) begin
        margin = 2 * sz < SplitCap ? 2 * sz : SplitCap;
        r.gaddr = AddrW'(ext_start[best]);
        if (best_sz >= sz + margin) begin
          ext_start[best] = (ext_start[best] + sz) & 16'hFFFF;
          ext_size[best]  = (best_sz - sz) & 17'h1FFFF;
          r.gbytes = SizeW'(sz);
        end else begin
          r.gbytes = SizeW'(best_sz);
          drop_extent(best);
        end
        if (live_n < 65535) live_n++;
      end else if (bump > pool || pool - bump < sz) begin
        r.status = StOom;
      end else begin
        r.gaddr = AddrW'(bump);
        r.gbytes = SizeW'(sz);
        bump = (bump + sz) & 17'h1FFFF;
        if (live_n < 65535) live_n++;
      end
    end else begin
      fin = it.addr + it.bytes;
      pos = 0;
      while (pos < ext_cnt && ext_start[pos] < it.addr) pos++;
      hp = pos > 0;
      hn = pos < ext_cnt;
      if (live_n == 0) r.status = StDup;
      else if (hn && (ext_start[pos] == it.addr || fin > ext_start[pos])) r.status = StDup;
      else if (hp && ext_start[pos-1] + ext_size[pos-1] > it.addr) r.status = StDup;
      else begin
        jp = hp && ext_start[pos-1] + ext_size[pos-1] == it.addr;
        jn = hn && fin == ext_start[pos];
        if (jp && jn) begin
          ext_size[pos-1] = (ext_size[pos-1] + it.bytes + ext_size[pos]) & 17'h1FFFF;
          drop_extent(pos);
        end else if (jp) begin
          ext_size[pos-1] = (ext_size[pos-1] + it.bytes) & 17'h1FFFF;
        end else if (jn) begin
          ext_start[pos] = it.addr;
          ext_size[pos] = (ext_size[pos] + it.bytes) & 17'h1FFFF;
        end else if (ext_cnt >= Slots) begin
          r.status = StFull;
        end else begin
          for (int unsigned j = ext_cnt; j > pos; j--) begin
            ext_start[j] = ext_start[j-1];
            ext_size[j] = ext_size[j-1];
          end
          ext_start[pos] = it.addr;
          ext_size[pos] = it.bytes;
          ext_cnt++;
        end
        if (r.status == StOk) begin
          live_n--;
          if (live_n == 0) begin
            ext_cnt = 0;
            bump = 0;
          end
        end
      end
    end
    r.nfree = FreeOutW'(ext_cnt);
    r.live = LiveW'(live_n);
    return r;
  endfunction

  // sender: hand over one item, expectation queued at acceptance
  task automatic send_item(alloc_item_t it, bit chk = 0, grant_t want = '0);
    grant_t g;
    req_if.valid <= 1'b1;
    req_if.op <= it.op;
    req_if.req_bytes <= it.req;
    req_if.blk_addr <= it.addr;
    req_if.blk_bytes <= it.bytes;
    do @(posedge clk_i); while (!req_if.ready);
    g = predict_grant(it);
    if (chk) begin
      if (g.status != want.status) report("row status", 32'(g.status), 32'(want.status));
      if (g.gaddr != want.gaddr) report("row grant_addr", 32'(g.gaddr), 32'(want.gaddr));
      if (g.gbytes != want.gbytes) report("row grant_bytes", 32'(g.gbytes), 32'(want.gbytes));
      if (g.nfree != want.nfree) report("row free_extents", 32'(g.nfree), 32'(want.nfree));
      if (g.live != want.live) report("row live_count", 32'(g.live), 32'(want.live));
    end
    grant_q.push_back(g);
    if (it.op == OpAlloc && g.status == StOk) begin
      live_q.push_back('{op: OpFree, req: '0, addr: g.gaddr, bytes: g.gbytes});
    end else if (it.op == OpFree && g.status == StOk) begin
      foreach (live_q[i]) if (live_q[i].addr == it.addr && live_q[i].bytes == it.bytes) begin
        live_q.delete(i);
        break;
      end
    end
    if (g.live == 0) live_q.delete();
  endtask

  task automatic gap_cycles(int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk_i);
    repeat (2 * Slots + 10) @(posedge clk_i);
  endtask

  task automatic set_pool(int unsigned v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= SizeW'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pool_reg = v & 17'h1FFFF;
  endtask

  function automatic alloc_item_t mk_alloc(int unsigned r);
    return '{op: OpAlloc, req: AddrW'(r), addr: '0, bytes: '0};
  endfunction

  function automatic alloc_item_t mk_free(int unsigned a, int unsigned b);
    return '{op: OpFree, req: '0, addr: AddrW'(a), bytes: SizeW'(b)};
  endfunction

  // receiver: stall pattern plus a long hold-off on request
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_rsp) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= ($urandom_range(0, 3) != 0) || (grant_q.size() % 7 == 3);
    end
  end

  // response checker
  always @(posedge clk_i) begin
    grant_t w;
    if (rsp_if.valid && rsp_if.ready) begin
      if (grant_q.size() == 0) begin
        report("unexpected item", 32'(rsp_if.status), 0);
      end else begin
        w = grant_q.pop_front();
        if (rsp_if.status !== w.status)
          report("status", 32'(rsp_if.status), 32'(w.status));
        if (rsp_if.grant_addr !== w.gaddr)
          report("grant_addr", 32'(rsp_if.grant_addr), 32'(w.gaddr));
        if (rsp_if.grant_bytes !== w.gbytes)
          report("grant_bytes", 32'(rsp_if.grant_bytes), 32'(w.gbytes));
        if (rsp_if.free_extents !== w.nfree)
          report("free_extents", 32'(rsp_if.free_extents), 32'(w.nfree));
        if (rsp_if.live_count !== w.live)
          report("live_count", 32'(rsp_if.live_count), 32'(w.live));
      end
    end
  end

  // watchdog: count cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles <= 0;
    else if (req_if.valid || grant_q.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles > Limit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    alloc_item_t it;
    int n;
    req_if.valid = 1'b0;
    req_if.op = OpAlloc;
    req_if.req_bytes = '0;
    req_if.blk_addr = '0;
    req_if.blk_bytes = '0;
    pool_reg = PoolReset;
    ext_cnt = 0;
    bump = 0;
    live_n = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: free with nothing live, extremes, splits, merges, repeat frees
    rows.push_back('{mk_free(0, 32), 1, '{StDup, 0, 0, 0, 0}});
    rows.push_back('{mk_alloc(0), 1, '{StOk, 0, 24, 0, 1}});
    rows.push_back('{mk_alloc(65535), 1, '{StOom, 0, 0, 0, 1}});
    rows.push_back('{mk_alloc(1000), 1, '{StOk, 24, 1024, 0, 2}});
    rows.push_back('{mk_alloc(40), 1, '{StOk, 1048, 64, 0, 3}});
    rows.push_back('{mk_alloc(100), 0, '0});
    rows.push_back('{mk_free(24, 1024), 1, '{StOk, 0, 0, 1, 3}});
    rows.push_back('{mk_free(24, 1024), 1, '{StDup, 0, 0, 1, 3}});
    rows.push_back('{mk_free(100, 8), 1, '{StDup, 0, 0, 1, 3}});
    rows.push_back('{mk_alloc(8), 0, '0});
    rows.push_back('{mk_alloc(1000), 0, '0});
    rows.push_back('{mk_free(1048, 64), 0, '0});
    rows.push_back('{mk_free(0, 24), 0, '0});
    rows.push_back('{mk_alloc(0), 0, '0});
    rows.push_back('{mk_free(65535, 17'h1FFFF), 0, '0});
    rows.push_back('{mk_alloc(65535), 0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].chk, rows[i].res);

    // table full: many separated frees
    set_pool(8192);
    repeat (40) send_item(mk_alloc(8));
    for (int i = 0; i < 40; i += 2) send_item(mk_free(i * 32, 32));
    repeat (300) send_item(mk_alloc($urandom_range(0, 65535)));
    for (int i = 0; i < 40; i++) send_item(mk_free(i * 32, 32));
    set_pool(0);
    set_pool(17'h1FFFF);
    set_pool(PoolReset);

    // random: mostly well-formed alloc/free of live chunks, some noise
    for (int k = 0; k < 1500; k++) begin
      if (k == 400) set_pool($urandom_range(8192, 20000));
      if (k == 900) set_pool(65536);
      if (k == 1200) begin
        hold_rsp = 1'b1;
        fork
          begin repeat (300) @(posedge clk_i); hold_rsp = 1'b0; end
        join_none
      end
      if (k == 1300) drain();
      n = $urandom_range(0, 9);
      if (n < 5) begin
        it = mk_alloc($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 600));
      end else if (n < 9 && live_q.size() != 0) begin
        it = live_q[$urandom_range(0, live_q.size() - 1)];
      end else begin
        it = '{op: 1'($urandom), req: AddrW'($urandom), addr: AddrW'($urandom),
               bytes: SizeW'($urandom)};
      end
      send_item(it);
      if ($urandom_range(0, 15) == 0) gap_cycles($urandom_range(1, 40));
    end
    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
